[design/lcc_pkg.sv]
// Shared types, register codes and constants of the LED colour conditioner.
package lcc_pkg;

   localparam int LED_COUNT_DEFAULT    = 256;
   localparam int WORK_DEPTH_DEFAULT   = 4;
   localparam int RESULT_DEPTH_DEFAULT = 2;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic       KIND_TICK      = 1'b1;
   localparam logic [8:0] BRIGHTNESS_ONE = 9'd256;

   typedef enum logic [2:0] {
      REG_BRIGHTNESS   = 3'd0,
      REG_WHITE_LUMA   = 3'd1,
      REG_WHITE_DIFF   = 3'd2,
      REG_COLOUR_LUMA  = 3'd3,
      REG_OUTLIER_DIFF = 3'd4,
      REG_LUMA_WEIGHTS = 3'd5,
      REG_DEDUP_ENABLE = 3'd6,
      REG_TIMEOUT_MS   = 3'd7
   } cfg_reg_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] led_index;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [7:0] led_out;
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic       kind;
      logic [7:0] led_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } work_type;

   typedef struct packed {
      logic [8:0]  brightness;
      logic [9:0]  white_luma_thresh;
      logic [7:0]  white_diff_thresh;
      logic [9:0]  colour_luma_thresh;
      logic [7:0]  outlier_diff_thresh;
      logic [26:0] luma_weights;
      logic        dedup_enable;
      logic [15:0] timeout_ms;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      brightness:          BRIGHTNESS_ONE,
      white_luma_thresh:   10'd0,
      white_diff_thresh:   8'd0,
      colour_luma_thresh:  10'd0,
      outlier_diff_thresh: 8'd255,
      luma_weights:        27'd0,
      dedup_enable:        1'b0,
      timeout_ms:          16'd0
   };

endpackage

[design/lcc_csr.sv]
// Configuration register file with APB-style write and read access.
module lcc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [lcc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [lcc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [lcc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output lcc_pkg::cfg_type                cfg
);
   import lcc_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   cfg_reg_type sel;
   logic        wr_en;

   assign pready = 1'b1;
   assign sel    = cfg_reg_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite && pready;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (sel)
            REG_BRIGHTNESS:   cfg_in.brightness          = pwdata[8:0];
            REG_WHITE_LUMA:   cfg_in.white_luma_thresh   = pwdata[9:0];
            REG_WHITE_DIFF:   cfg_in.white_diff_thresh   = pwdata[7:0];
            REG_COLOUR_LUMA:  cfg_in.colour_luma_thresh  = pwdata[9:0];
            REG_OUTLIER_DIFF: cfg_in.outlier_diff_thresh = pwdata[7:0];
            REG_LUMA_WEIGHTS: cfg_in.luma_weights        = pwdata[26:0];
            REG_DEDUP_ENABLE: cfg_in.dedup_enable        = pwdata[0];
            REG_TIMEOUT_MS:   cfg_in.timeout_ms          = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (sel)
         REG_BRIGHTNESS:   prdata[8:0]  = cfg_ff.brightness;
         REG_WHITE_LUMA:   prdata[9:0]  = cfg_ff.white_luma_thresh;
         REG_WHITE_DIFF:   prdata[7:0]  = cfg_ff.white_diff_thresh;
         REG_COLOUR_LUMA:  prdata[9:0]  = cfg_ff.colour_luma_thresh;
         REG_OUTLIER_DIFF: prdata[7:0]  = cfg_ff.outlier_diff_thresh;
         REG_LUMA_WEIGHTS: prdata[26:0] = cfg_ff.luma_weights;
         REG_DEDUP_ENABLE: prdata[0]    = cfg_ff.dedup_enable;
         REG_TIMEOUT_MS:   prdata[15:0] = cfg_ff.timeout_ms;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[design/lcc_queue.sv]
// Small synchronous FIFO with push/full and pop/empty sides.
module lcc_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (PW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem[rd_ptr_ff];

   // pointers wrap at the last entry so any depth works
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PW'(1);
      end
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[design/lcc_front.sv]
// Front end: accepts items, scales, computes luma and conditions the colour.
module lcc_front #(
   parameter int LED_COUNT = lcc_pkg::LED_COUNT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  lcc_pkg::req_type  req_data,
   input  lcc_pkg::cfg_type  cfg,
   output logic              q_push,
   output lcc_pkg::work_type q_data,
   input  logic              q_full
);
   import lcc_pkg::*;

   function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic logic is_outlier(input logic [7:0] c, input logic [7:0] o1,
                                       input logic [7:0] o2, input logic [7:0] th);
      return (c < o1) && (c < o2) && ((o1 - c) > th) && ((o2 - c) > th);
   endfunction

   logic        advance, accept, in_range;
   logic        s1_valid_ff, s1_valid_in;
   logic        s2_valid_ff;
   work_type    s1_ff, s1_in;
   work_type    s2_ff;
   logic [10:0] s2_luma_ff, luma_in;
   logic [16:0] prod_r, prod_g, prod_b;
   logic [16:0] lum_r, lum_g, lum_b;
   logic [18:0] lum_sum;
   logic        white, blank;

   // whole pipe holds while the last stage waits on the queue
   assign advance = !(s2_valid_ff && q_full);
   assign full    = !advance;
   assign accept  = push && advance;
   assign in_range = {1'b0, req_data.led_index} < 9'(LED_COUNT);

   // stage 1: brightness scaling
   assign prod_r = 17'(req_data.red_in)   * 17'(cfg.brightness);
   assign prod_g = 17'(req_data.green_in) * 17'(cfg.brightness);
   assign prod_b = 17'(req_data.blue_in)  * 17'(cfg.brightness);

   always_comb begin
      s1_valid_in     = accept && (req_data.kind == KIND_TICK || in_range);
      s1_in.kind      = req_data.kind;
      s1_in.led_index = req_data.led_index;
      // bit 8 set means factor of 1.0 or more: pass through
      s1_in.red   = cfg.brightness[8] ? req_data.red_in   : prod_r[15:8];
      s1_in.green = cfg.brightness[8] ? req_data.green_in : prod_g[15:8];
      s1_in.blue  = cfg.brightness[8] ? req_data.blue_in  : prod_b[15:8];
   end

   // stage 2: weighted luma
   assign lum_r   = 17'(cfg.luma_weights[26:18]) * 17'(s1_ff.red);
   assign lum_g   = 17'(cfg.luma_weights[17:9])  * 17'(s1_ff.green);
   assign lum_b   = 17'(cfg.luma_weights[8:0])   * 17'(s1_ff.blue);
   assign lum_sum = 19'(lum_r) + 19'(lum_g) + 19'(lum_b);
   assign luma_in = lum_sum[18:8];

   // stage 3: blanking and outlier removal, written into the queue
   always_comb begin
      q_data = s2_ff;
      white  = (abs_diff(s2_ff.red, s2_ff.green) <= cfg.white_diff_thresh) &&
               (abs_diff(s2_ff.red, s2_ff.blue)  <= cfg.white_diff_thresh) &&
               (abs_diff(s2_ff.green, s2_ff.blue) <= cfg.white_diff_thresh);
      blank  = white ? (s2_luma_ff < {1'b0, cfg.white_luma_thresh})
                     : (s2_luma_ff < {1'b0, cfg.colour_luma_thresh});
      if (blank) begin
         q_data.red   = '0;
         q_data.green = '0;
         q_data.blue  = '0;
      end else if (!white) begin
         if (is_outlier(s2_ff.red, s2_ff.green, s2_ff.blue, cfg.outlier_diff_thresh)) begin
            q_data.red = '0;
         end else if (is_outlier(s2_ff.green, s2_ff.red, s2_ff.blue,
                                 cfg.outlier_diff_thresh)) begin
            q_data.green = '0;
         end else if (is_outlier(s2_ff.blue, s2_ff.green, s2_ff.red,
                                 cfg.outlier_diff_thresh)) begin
            q_data.blue = '0;
         end
      end
   end

   assign q_push = s2_valid_ff && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff      <= s1_in;
         s2_ff      <= s1_ff;
         s2_luma_ff <= luma_in;
      end
   end

endmodule

[design/lcc_back.sv]
// Back end: per-LED dedup and send interval against stored state, tick counter.
module lcc_back #(
   parameter int LED_COUNT = lcc_pkg::LED_COUNT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  lcc_pkg::cfg_type  cfg,
   input  lcc_pkg::work_type q_data,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              o_push,
   output lcc_pkg::rsp_type  o_data,
   input  logic              o_full
);
   import lcc_pkg::*;

   localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EVAL = 2'b10
   } state_type;

   state_type      state_ff, state_in;
   logic [23:0]    prev_mem [LED_COUNT];
   logic [31:0]    time_mem [LED_COUNT];
   logic [LED_COUNT-1:0] prev_valid_ff, prev_valid_in;
   logic [LED_COUNT-1:0] sent_valid_ff, sent_valid_in;
   work_type       item_ff;
   logic [23:0]    prev_rd_ff;
   logic [31:0]    time_rd_ff;
   logic           prev_vld_rd_ff, sent_rd_ff;
   logic [31:0]    ms_ff, ms_in;
   logic [AW-1:0]  rd_addr, wr_addr;
   logic           start, is_tick;
   logic [23:0]    colour, prev;
   logic [31:0]    elapsed;
   logic           timer_on, same, blocked, pass, done;
   logic           prev_we, time_we;

   assign rd_addr = q_data.led_index[AW-1:0];
   assign wr_addr = item_ff.led_index[AW-1:0];
   assign is_tick = (q_data.kind == KIND_TICK);
   assign start   = (state_ff == ST_IDLE) && !q_empty;
   assign q_pop   = start;

   assign colour   = {item_ff.red, item_ff.green, item_ff.blue};
   assign prev     = prev_vld_rd_ff ? prev_rd_ff : '0;
   assign elapsed  = ms_ff - time_rd_ff;
   assign timer_on = (cfg.timeout_ms != '0);
   assign same     = cfg.dedup_enable && (prev == colour);
   assign blocked  = timer_on && sent_rd_ff && (elapsed < {16'd0, cfg.timeout_ms});
   assign pass     = !same && !blocked;
   // a passing item waits here until the result queue has room
   assign done     = (state_ff == ST_EVAL) && (!pass || !o_full);
   assign prev_we  = done && cfg.dedup_enable;
   assign time_we  = done && pass && timer_on;

   assign o_push = done && pass;
   assign o_data = '{led_out: item_ff.led_index, red_out: item_ff.red,
                     green_out: item_ff.green, blue_out: item_ff.blue};

   always_comb begin
      state_in      = state_ff;
      ms_in         = ms_ff;
      prev_valid_in = prev_valid_ff;
      sent_valid_in = sent_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (is_tick) begin
                  ms_in = ms_ff + 32'd1;
               end else begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_EVAL: begin
            if (done) begin
               state_in = ST_IDLE;
            end
            if (prev_we) begin
               prev_valid_in[wr_addr] = 1'b1;
            end
            if (time_we) begin
               sent_valid_in[wr_addr] = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[wr_addr] <= colour;
      end
      if (time_we) begin
         time_mem[wr_addr] <= ms_ff;
      end
      if (start) begin
         item_ff        <= q_data;
         prev_rd_ff     <= prev_mem[rd_addr];
         time_rd_ff     <= time_mem[rd_addr];
         prev_vld_rd_ff <= prev_valid_ff[rd_addr];
         sent_rd_ff     <= sent_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ms_ff         <= '0;
         prev_valid_ff <= '0;
         sent_valid_ff <= '0;
      end else begin
         state_ff      <= state_in;
         ms_ff         <= ms_in;
         prev_valid_ff <= prev_valid_in;
         sent_valid_ff <= sent_valid_in;
      end
   end

endmodule

[design/led_chunk_colour_conditioner.sv]
// A colour goes through the front pipe, work queue, back and result queue; ticks
// and dropped colours give no result. Throughput: the front takes one item per
// cycle unless the work queue stalls it; the back reads state memory, then updates
// it once the result queue has room (a tick needs only the read step), and takes no
// new item until done. Reset: synchronous; clears queues, pipeline, per-LED valid
// bits, ms counter and sets registers to their reset values, with no clearing pass.
module led_chunk_colour_conditioner #(
   parameter int LED_COUNT    = lcc_pkg::LED_COUNT_DEFAULT,
   parameter int WORK_DEPTH   = lcc_pkg::WORK_DEPTH_DEFAULT,
   parameter int RESULT_DEPTH = lcc_pkg::RESULT_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  lcc_pkg::req_type               req_data,
   output logic                           empty,
   input  logic                           pop,
   output lcc_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [lcc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lcc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [lcc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import lcc_pkg::*;

   cfg_type  cfg;
   work_type front_data, back_data;
   logic     wq_push, wq_full, wq_pop, wq_empty;
   rsp_type  back_rsp, rq_data;
   logic     rq_push, rq_full;

   lcc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lcc_front #(.LED_COUNT(LED_COUNT)) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .cfg      (cfg),
      .q_push   (wq_push),
      .q_data   (front_data),
      .q_full   (wq_full)
   );

   lcc_queue #(.WIDTH($bits(work_type)), .DEPTH(WORK_DEPTH)) u_work_q (
      .clock   (clock),
      .reset   (reset),
      .push    (wq_push),
      .wr_data (front_data),
      .full    (wq_full),
      .pop     (wq_pop),
      .rd_data (back_data),
      .empty   (wq_empty)
   );

   lcc_back #(.LED_COUNT(LED_COUNT)) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_data  (back_data),
      .q_empty (wq_empty),
      .q_pop   (wq_pop),
      .o_push  (rq_push),
      .o_data  (back_rsp),
      .o_full  (rq_full)
   );

   lcc_queue #(.WIDTH($bits(rsp_type)), .DEPTH(RESULT_DEPTH)) u_result_q (
      .clock   (clock),
      .reset   (reset),
      .push    (rq_push),
      .wr_data (back_rsp),
      .full    (rq_full),
      .pop     (pop),
      .rd_data (rq_data),
      .empty   (empty)
   );

   assign rsp_data = rq_data;

endmodule

[design/lcc_checker.sv]
// Port-level assertions for the colour conditioner and their bind to the top level.
module lcc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           full,
   input logic                           empty,
   input logic                           pop,
   input lcc_pkg::rsp_type               rsp_data,
   input logic                           psel,
   input logic                           penable,
   input logic                           pwrite,
   input logic [lcc_pkg::CSR_ADDR_W-1:0] paddr,
   input logic [lcc_pkg::CSR_DATA_W-1:0] pwdata,
   input logic [lcc_pkg::CSR_DATA_W-1:0] prdata,
   input logic                           pready
);
   import lcc_pkg::*;

   logic csr_wr;
   assign csr_wr = psel && penable && pwrite && pready;

   // reset leaves both queue sides idle
   a_reset_idle: assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queues not idle after reset");

   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result changed before pop");

   a_brightness_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && paddr[CSR_ADDR_W-1:2] == REG_BRIGHTNESS) |=>
      (paddr[CSR_ADDR_W-1:2] != REG_BRIGHTNESS || prdata[8:0] == $past(pwdata[8:0])))
      else $error("brightness readback mismatch");

   a_timeout_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && paddr[CSR_ADDR_W-1:2] == REG_TIMEOUT_MS) |=>
      (paddr[CSR_ADDR_W-1:2] != REG_TIMEOUT_MS || prdata[15:0] == $past(pwdata[15:0])))
      else $error("timeout readback mismatch");

endmodule

bind led_chunk_colour_conditioner lcc_checker u_lcc_checker (.*);

[tb/sv/led_chunk_colour_conditioner_tb.sv]
// Self-checking testbench for the LED chunk colour conditioner.
module led_chunk_colour_conditioner_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lcc_pkg::*;

   localparam int STALL_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 80;

   logic        clock   = 1'b0;
   logic        reset   = 1'b1;
   logic        push    = 1'b0;
   logic        full;
   req_type     req_data = '0;
   logic        empty;
   logic        pop     = 1'b0;
   rsp_type     rsp_data;
   logic        psel    = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr  = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic        pready;

   // conditioner state as the block should hold it
   cfg_type     model_cfg;
   logic [23:0] stored_colour [256];
   logic [31:0] sent_at_ms [256];
   logic        sent_once [256];
   logic [31:0] ms_now;
   logic [23:0] last_rgb_in [256];

   rsp_type     pending_colours [$];
   rsp_type     oldest_colour;

   int send_gap_max = 12;
   int rsp_gap_max  = 12;
   int rsp_hold     = 0;
   int fail_count   = 0;
   int items_sent   = 0;
   int ticks_sent   = 0;
   int results_checked = 0;
   int settings_used   = 0;
   int idle_cycles     = 0;

   led_chunk_colour_conditioner uut (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [7:0] chan_gap(logic [7:0] a, logic [7:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic bit weakest_outlier(logic [7:0] c, logic [7:0] o1, logic [7:0] o2,
                                          logic [7:0] th);
      return c < o1 && c < o2 && (o1 - c) > th && (o2 - c) > th;
   endfunction

   // bits of a register that read back
   function automatic logic [31:0] reg_mask(cfg_reg_type sel);
      case (sel)
         REG_BRIGHTNESS:   return 32'h0000_01FF;
         REG_WHITE_LUMA:   return 32'h0000_03FF;
         REG_WHITE_DIFF:   return 32'h0000_00FF;
         REG_COLOUR_LUMA:  return 32'h0000_03FF;
         REG_OUTLIER_DIFF: return 32'h0000_00FF;
         REG_LUMA_WEIGHTS: return 32'h07FF_FFFF;
         REG_DEDUP_ENABLE: return 32'h0000_0001;
         REG_TIMEOUT_MS:   return 32'h0000_FFFF;
         default:          return 32'h0000_0000;
      endcase
   endfunction

   // conditions one accepted item and queues the colour it should send, if any
   task automatic condition_colour(req_type it);
      logic [7:0]  r, g, b, idx;
      logic [16:0] scaled;
      logic [18:0] weighted;
      logic [10:0] luma;
      logic [23:0] colour;
      bit          same;
      if (it.kind == KIND_TICK) begin
         ms_now = ms_now + 32'd1;
         return;
      end
      idx = it.led_index;
      r = it.red_in;
      g = it.green_in;
      b = it.blue_in;
      if (model_cfg.brightness < BRIGHTNESS_ONE) begin
         scaled = 17'(r) * 17'(model_cfg.brightness);
         r = scaled[15:8];
         scaled = 17'(g) * 17'(model_cfg.brightness);
         g = scaled[15:8];
         scaled = 17'(b) * 17'(model_cfg.brightness);
         b = scaled[15:8];
      end
      weighted = 19'(model_cfg.luma_weights[26:18]) * 19'(r)
               + 19'(model_cfg.luma_weights[17:9]) * 19'(g)
               + 19'(model_cfg.luma_weights[8:0]) * 19'(b);
      luma = weighted[18:8];
      if (chan_gap(r, g) <= model_cfg.white_diff_thresh &&
          chan_gap(r, b) <= model_cfg.white_diff_thresh &&
          chan_gap(g, b) <= model_cfg.white_diff_thresh) begin
         if (luma < {1'b0, model_cfg.white_luma_thresh}) begin
            r = 8'd0; g = 8'd0; b = 8'd0;
         end
      end else if (luma < {1'b0, model_cfg.colour_luma_thresh}) begin
         r = 8'd0; g = 8'd0; b = 8'd0;
      end else if (weakest_outlier(r, g, b, model_cfg.outlier_diff_thresh)) begin
         r = 8'd0;
      end else if (weakest_outlier(g, r, b, model_cfg.outlier_diff_thresh)) begin
         g = 8'd0;
      end else if (weakest_outlier(b, g, r, model_cfg.outlier_diff_thresh)) begin
         b = 8'd0;
      end
      colour = {r, g, b};
      if (model_cfg.dedup_enable) begin
         same = (stored_colour[idx] == colour);
         stored_colour[idx] = colour;
         if (same) return;
      end
      if (model_cfg.timeout_ms != 16'd0) begin
         if (sent_once[idx] &&
             (ms_now - sent_at_ms[idx]) < {16'd0, model_cfg.timeout_ms}) return;
         sent_at_ms[idx] = ms_now;
         sent_once[idx] = 1'b1;
      end
      pending_colours.push_back('{led_out: idx, red_out: r, green_out: g, blue_out: b});
   endtask

   function automatic req_type colour_item(logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                                           logic [7:0] b);
      return '{kind: ~KIND_TICK, led_index: idx, red_in: r, green_in: g, blue_in: b};
   endfunction

   function automatic req_type tick_item();
      return '{kind: KIND_TICK, led_index: 8'd0, red_in: 8'd0, green_in: 8'd0, blue_in: 8'd0};
   endfunction

   // mostly a few hot indexes so dedup and interval checks see repeats
   function automatic req_type random_item();
      req_type     it;
      int unsigned pick;
      logic [7:0]  base;
      it.kind = ($urandom_range(0, 4) == 0) ? KIND_TICK : ~KIND_TICK;
      pick = $urandom_range(0, 9);
      if (pick < 5) it.led_index = 8'($urandom_range(0, 3));
      else if (pick == 5) it.led_index = 8'd255;
      else it.led_index = 8'($urandom);
      pick = $urandom_range(0, 19);
      if (pick < 5) begin
         {it.red_in, it.green_in, it.blue_in} = last_rgb_in[it.led_index];
      end else if (pick < 9) begin
         base = 8'($urandom_range(0, 240));
         it.red_in   = base + 8'($urandom_range(0, 15));
         it.green_in = base + 8'($urandom_range(0, 15));
         it.blue_in  = base + 8'($urandom_range(0, 15));
      end else if (pick < 12) begin
         it.red_in   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
         it.green_in = $urandom_range(0, 1) ? 8'd255 : 8'd0;
         it.blue_in  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end else begin
         it.red_in   = 8'($urandom);
         it.green_in = 8'($urandom);
         it.blue_in  = 8'($urandom);
      end
      last_rgb_in[it.led_index] = {it.red_in, it.green_in, it.blue_in};
      return it;
   endfunction

   // leaves push high so back-to-back items need no extra step
   task automatic send_item(req_type it);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (full);
      items_sent++;
      if (it.kind == KIND_TICK) ticks_sent++;
      condition_colour(it);
   endtask

   // dropped colours may still be in flight after the last result, hence the settle
   task automatic wait_all_results();
      push <= 1'b0;
      while (pending_colours.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(cfg_reg_type sel, logic [31:0] value);
      logic [31:0] readback;
      readback = value & reg_mask(sel);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (sel)
         REG_BRIGHTNESS:   model_cfg.brightness          = value[8:0];
         REG_WHITE_LUMA:   model_cfg.white_luma_thresh   = value[9:0];
         REG_WHITE_DIFF:   model_cfg.white_diff_thresh   = value[7:0];
         REG_COLOUR_LUMA:  model_cfg.colour_luma_thresh  = value[9:0];
         REG_OUTLIER_DIFF: model_cfg.outlier_diff_thresh = value[7:0];
         REG_LUMA_WEIGHTS: model_cfg.luma_weights        = value[26:0];
         REG_DEDUP_ENABLE: model_cfg.dedup_enable        = value[0];
         REG_TIMEOUT_MS:   model_cfg.timeout_ms          = value[15:0];
         default: ;
      endcase
      @(posedge clock);
      // address is still on the bus, so the new value reads back
      if (prdata !== readback) begin
         $display("%0t: register %0d readback expected %0h actual %0h", $time, sel,
                  readback, prdata);
         fail_count++;
      end
   endtask

   task automatic write_all_regs(logic [31:0] bright, logic [31:0] wluma, logic [31:0] wdiff,
                                 logic [31:0] cluma, logic [31:0] odiff, logic [31:0] weights,
                                 logic [31:0] dedup, logic [31:0] tmo);
      csr_write(REG_BRIGHTNESS, bright);
      csr_write(REG_WHITE_LUMA, wluma);
      csr_write(REG_WHITE_DIFF, wdiff);
      csr_write(REG_COLOUR_LUMA, cluma);
      csr_write(REG_OUTLIER_DIFF, odiff);
      csr_write(REG_LUMA_WEIGHTS, weights);
      csr_write(REG_DEDUP_ENABLE, dedup);
      csr_write(REG_TIMEOUT_MS, tmo);
      settings_used++;
   endtask

   task automatic random_settings();
      logic [31:0] bright, tmo;
      int unsigned pick;
      pick = $urandom_range(0, 2);
      if (pick == 0) bright = 32'(BRIGHTNESS_ONE);
      else if (pick == 1) bright = $urandom_range(0, 255);
      else bright = $urandom_range(257, 511);
      pick = $urandom_range(0, 9);
      if (pick < 5) tmo = 32'd0;
      else if (pick < 9) tmo = $urandom_range(1, 10);
      else tmo = $urandom_range(0, 65535);
      write_all_regs(bright, $urandom_range(0, 400), $urandom_range(0, 40),
                     $urandom_range(0, 400), $urandom_range(0, 255),
                     $urandom_range(0, 27'h7FFFFFF), $urandom_range(0, 1), tmo);
   endtask

   task automatic test_directed_cases();
      send_gap_max = 0;
      rsp_gap_max  = 0;
      // reset settings pass colours straight through
      send_item(colour_item(8'd0, 8'd0, 8'd0, 8'd0));
      send_item(colour_item(8'd255, 8'd255, 8'd255, 8'd255));
      send_item(colour_item(8'h55, 8'hAA, 8'h55, 8'hAA));
      send_item(colour_item(8'hAA, 8'h55, 8'hAA, 8'h55));
      send_item(tick_item());
      wait_all_results();
      csr_write(REG_BRIGHTNESS, 32'd0);
      send_item(colour_item(8'd3, 8'd200, 8'd100, 8'd50));
      wait_all_results();
      csr_write(REG_BRIGHTNESS, 32'd128);
      send_item(colour_item(8'd3, 8'd255, 8'd101, 8'd1));
      wait_all_results();
      // factor above one acts as no scaling
      csr_write(REG_BRIGHTNESS, 32'd511);
      send_item(colour_item(8'd3, 8'd255, 8'd101, 8'd1));
      wait_all_results();
      // blanking: grey and coloured dark items, full white survives
      csr_write(REG_LUMA_WEIGHTS, 32'h07FF_FFFF);
      csr_write(REG_WHITE_LUMA, 32'd1023);
      csr_write(REG_COLOUR_LUMA, 32'd1023);
      send_item(colour_item(8'd4, 8'd100, 8'd100, 8'd100));
      send_item(colour_item(8'd4, 8'd200, 8'd10, 8'd10));
      send_item(colour_item(8'd4, 8'd255, 8'd255, 8'd255));
      wait_all_results();
      // weakest channel removal, each channel in turn, then a tie
      csr_write(REG_WHITE_LUMA, 32'd0);
      csr_write(REG_COLOUR_LUMA, 32'd0);
      csr_write(REG_OUTLIER_DIFF, 32'd0);
      send_item(colour_item(8'd5, 8'd200, 8'd100, 8'd50));
      send_item(colour_item(8'd5, 8'd10, 8'd200, 8'd200));
      send_item(colour_item(8'd5, 8'd200, 8'd5, 8'd100));
      send_item(colour_item(8'd5, 8'd50, 8'd50, 8'd200));
      wait_all_results();
      // repeated colour dropped; black matches the cleared store
      csr_write(REG_DEDUP_ENABLE, 32'd1);
      send_item(colour_item(8'd7, 8'd30, 8'd40, 8'd50));
      send_item(colour_item(8'd7, 8'd30, 8'd40, 8'd50));
      send_item(colour_item(8'd8, 8'd0, 8'd0, 8'd0));
      wait_all_results();
      // per-LED send interval
      csr_write(REG_DEDUP_ENABLE, 32'd0);
      csr_write(REG_TIMEOUT_MS, 32'd3);
      send_item(colour_item(8'd9, 8'd1, 8'd2, 8'd3));
      send_item(colour_item(8'd9, 8'd1, 8'd2, 8'd3));
      repeat (3) send_item(tick_item());
      send_item(colour_item(8'd9, 8'd1, 8'd2, 8'd3));
      wait_all_results();
      settings_used++;
   endtask

   task automatic test_register_extremes();
      send_gap_max = 12;
      rsp_gap_max  = 12;
      write_all_regs(0, 0, 0, 0, 0, 0, 0, 0);
      repeat (30) send_item(random_item());
      wait_all_results();
      write_all_regs(511, 1023, 255, 1023, 255, 32'h07FF_FFFF, 1, 65535);
      repeat (30) send_item(random_item());
      wait_all_results();
   endtask

   task automatic test_random_settings();
      for (int p = 0; p < 6; p++) begin
         send_gap_max = (p % 3 == 0) ? 0 : 12;
         rsp_gap_max  = (p % 2 == 0) ? 12 : 0;
         random_settings();
         repeat (100) send_item(random_item());
         wait_all_results();
      end
   endtask

   // receiver stops long enough for the input side to fill and push back
   task automatic test_result_backpressure();
      write_all_regs(32'(BRIGHTNESS_ONE), 0, 0, 0, 255, 0, 0, 0);
      send_gap_max = 0;
      rsp_gap_max  = 0;
      rsp_hold = HOLD_CYCLES;
      repeat (40) send_item(colour_item(8'($urandom), 8'($urandom), 8'($urandom),
                                        8'($urandom)));
      wait_all_results();
   endtask

   task automatic test_sender_pause();
      send_gap_max = 12;
      rsp_gap_max  = 12;
      random_settings();
      repeat (20) send_item(random_item());
      wait_all_results();
      repeat (20) send_item(random_item());
      wait_all_results();
   endtask

   initial begin
      pop <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold > 0) begin
            pop <= 1'b0;
            repeat (rsp_hold) @(posedge clock);
            rsp_hold = 0;
         end else begin
            int stall;
            stall = $urandom_range(0, rsp_gap_max);
            if (stall > 0) begin
               pop <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (pending_colours.size() == 0) begin
            $display("%0t: unexpected result led %0d rgb %02h %02h %02h", $time,
                     rsp_data.led_out, rsp_data.red_out, rsp_data.green_out,
                     rsp_data.blue_out);
            fail_count++;
         end else begin
            oldest_colour = pending_colours.pop_front();
            results_checked++;
            if (rsp_data.led_out !== oldest_colour.led_out) begin
               $display("%0t: led_out expected %0d actual %0d", $time,
                        oldest_colour.led_out, rsp_data.led_out);
               fail_count++;
            end
            if (rsp_data.red_out !== oldest_colour.red_out) begin
               $display("%0t: red_out expected %0d actual %0d", $time,
                        oldest_colour.red_out, rsp_data.red_out);
               fail_count++;
            end
            if (rsp_data.green_out !== oldest_colour.green_out) begin
               $display("%0t: green_out expected %0d actual %0d", $time,
                        oldest_colour.green_out, rsp_data.green_out);
               fail_count++;
            end
            if (rsp_data.blue_out !== oldest_colour.blue_out) begin
               $display("%0t: blue_out expected %0d actual %0d", $time,
                        oldest_colour.blue_out, rsp_data.blue_out);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
                  STALL_LIMIT, pending_colours.size());
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      model_cfg = CFG_RESET;
      ms_now = 32'd0;
      for (int i = 0; i < 256; i++) begin
         stored_colour[i] = 24'd0;
         sent_at_ms[i]    = 32'd0;
         sent_once[i]     = 1'b0;
         last_rgb_in[i]   = 24'd0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_register_extremes();
      test_random_settings();
      test_result_backpressure();
      test_sender_pause();
      wait_all_results();
      $display("Run covered %0d items (%0d ticks) under %0d register settings,",
               items_sent, ticks_sent, settings_used);
      $display("with %0d results compared and %0d mismatches.", results_checked, fail_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[led_chunk_colour_conditioner.f]
design/lcc_pkg.sv
design/lcc_csr.sv
design/lcc_queue.sv
design/lcc_front.sv
design/lcc_back.sv
design/led_chunk_colour_conditioner.sv
design/lcc_checker.sv
tb/sv/led_chunk_colour_conditioner_tb.sv
